[hw/rtl/triangle_rect_overlap_xz_macros.svh]
// Assertion macros shared by the triangle/cell overlap RTL.
`ifndef TRIANGLE_RECT_OVERLAP_XZ_MACROS_SVH
`define TRIANGLE_RECT_OVERLAP_XZ_MACROS_SVH

// Implication checked on every rising clock edge, off while in reset.
`define TROV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Plain check, also evaluated during reset.
`define TROV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/trov_pkg.sv]
// Shared constants, types and geometry tables for the overlap pipeline.
`default_nettype none
package trov_pkg;

  localparam int unsigned InW          = 32;  // coordinate port width
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned NumTri       = 3;
  localparam int unsigned NumCorner    = 4;
  localparam int unsigned NumCellEdge  = 4;
  // triangle edge vs cell corner, then cell edge vs triangle vertex
  localparam int unsigned NumA         = NumTri * NumCorner;
  localparam int unsigned NumB         = NumCellEdge * NumTri;
  localparam int unsigned NumTests     = NumA + NumB;

  // corner codes
  localparam logic [1:0] CornerLoLo = 2'd0;  // (min x, min z)
  localparam logic [1:0] CornerHiLo = 2'd1;  // (max x, min z)
  localparam logic [1:0] CornerLoHi = 2'd2;  // (min x, max z)
  localparam logic [1:0] CornerHiHi = 2'd3;  // (max x, max z)

  // enables for the product registers and the sign register inside an orientation unit
  typedef struct packed {
    logic en_mul;
    logic en_sub;
  } trov_ctl_t;

  function automatic logic [1:0] tri_next(input logic [1:0] i);
    logic [1:0] r;
    unique case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // first endpoint of a cell edge: bottom, top, left, right
  function automatic logic [1:0] edge_p0(input logic [1:0] e);
    logic [1:0] r;
    unique case (e)
      2'd0:    r = CornerLoLo;
      2'd1:    r = CornerLoHi;
      2'd2:    r = CornerLoLo;
      default: r = CornerHiLo;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] edge_p1(input logic [1:0] e);
    logic [1:0] r;
    unique case (e)
      2'd0:    r = CornerHiLo;
      2'd1:    r = CornerHiHi;
      2'd2:    r = CornerLoHi;
      default: r = CornerHiHi;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/trov_front.sv]
// Stage 1: coordinate wrap, containment compares and orientation differences.
`default_nettype none
module trov_front #(
  parameter int unsigned CW = trov_pkg::CoordWidthDef
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [trov_pkg::InW-1:0]     vertex_a_x_i,
  input  logic signed [trov_pkg::InW-1:0]     vertex_a_z_i,
  input  logic signed [trov_pkg::InW-1:0]     vertex_b_x_i,
  input  logic signed [trov_pkg::InW-1:0]     vertex_b_z_i,
  input  logic signed [trov_pkg::InW-1:0]     vertex_c_x_i,
  input  logic signed [trov_pkg::InW-1:0]     vertex_c_z_i,
  input  logic                                normal_points_down_i,
  input  logic signed [trov_pkg::InW-1:0]     cell_min_x_i,
  input  logic signed [trov_pkg::InW-1:0]     cell_min_z_i,
  input  logic signed [trov_pkg::InW-1:0]     cell_max_x_i,
  input  logic signed [trov_pkg::InW-1:0]     cell_max_z_i,
  output logic                                early_o,
  output logic signed [CW:0]                  da_o [trov_pkg::NumTests],
  output logic signed [CW:0]                  db_o [trov_pkg::NumTests],
  output logic signed [CW:0]                  dc_o [trov_pkg::NumTests],
  output logic signed [CW:0]                  dd_o [trov_pkg::NumTests]
);
  import trov_pkg::*;

  logic signed [CW-1:0] tx [NumTri];
  logic signed [CW-1:0] tz [NumTri];
  logic signed [CW-1:0] cx [NumCorner];
  logic signed [CW-1:0] cz [NumCorner];
  logic signed [CW:0]   da_d [NumTests], db_d [NumTests], dc_d [NumTests], dd_d [NumTests];
  logic signed [CW:0]   da_q [NumTests], db_q [NumTests], dc_q [NumTests], dd_q [NumTests];
  logic                 early_d, early_q;

  always_comb begin
    tx[0] = CW'(vertex_a_x_i);
    tz[0] = CW'(vertex_a_z_i);
    tx[1] = CW'(vertex_b_x_i);
    tz[1] = CW'(vertex_b_z_i);
    tx[2] = CW'(vertex_c_x_i);
    tz[2] = CW'(vertex_c_z_i);
    cx[CornerLoLo] = CW'(cell_min_x_i);
    cz[CornerLoLo] = CW'(cell_min_z_i);
    cx[CornerHiLo] = CW'(cell_max_x_i);
    cz[CornerHiLo] = CW'(cell_min_z_i);
    cx[CornerLoHi] = CW'(cell_min_x_i);
    cz[CornerLoHi] = CW'(cell_max_z_i);
    cx[CornerHiHi] = CW'(cell_max_x_i);
    cz[CornerHiHi] = CW'(cell_max_z_i);
  end

  // closed-cell containment of any vertex, or the downward flag
  always_comb begin
    early_d = normal_points_down_i;
    for (int v = 0; v < NumTri; v++) begin
      if (cx[CornerLoLo] <= tx[v] && tx[v] <= cx[CornerHiHi] &&
          cz[CornerLoLo] <= tz[v] && tz[v] <= cz[CornerHiHi]) begin
        early_d = 1'b1;
      end
    end
  end

  // f(A,B,C) = (B.z-A.z)(C.x-B.x) - (B.x-A.x)(C.z-B.z), differences only here
  always_comb begin
    logic [1:0] j;
    logic [1:0] p0;
    logic [1:0] p1;
    j  = '0;
    p0 = '0;
    p1 = '0;
    for (int i = 0; i < NumTri; i++) begin
      j = tri_next(2'(i));
      for (int k = 0; k < NumCorner; k++) begin
        da_d[i*NumCorner+k] = (CW+1)'(tz[j]) - (CW+1)'(tz[i]);
        db_d[i*NumCorner+k] = (CW+1)'(cx[k]) - (CW+1)'(tx[j]);
        dc_d[i*NumCorner+k] = (CW+1)'(tx[j]) - (CW+1)'(tx[i]);
        dd_d[i*NumCorner+k] = (CW+1)'(cz[k]) - (CW+1)'(tz[j]);
      end
    end
    for (int e = 0; e < NumCellEdge; e++) begin
      p0 = edge_p0(2'(e));
      p1 = edge_p1(2'(e));
      for (int v = 0; v < NumTri; v++) begin
        da_d[NumA+e*NumTri+v] = (CW+1)'(cz[p1]) - (CW+1)'(cz[p0]);
        db_d[NumA+e*NumTri+v] = (CW+1)'(tx[v]) - (CW+1)'(cx[p1]);
        dc_d[NumA+e*NumTri+v] = (CW+1)'(cx[p1]) - (CW+1)'(cx[p0]);
        dd_d[NumA+e*NumTri+v] = (CW+1)'(tz[v]) - (CW+1)'(cz[p1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      early_q <= early_d;
      da_q    <= da_d;
      db_q    <= db_d;
      dc_q    <= dc_d;
      dd_q    <= dd_d;
    end
  end

  assign early_o = early_q;
  assign da_o    = da_q;
  assign db_o    = db_q;
  assign dc_o    = dc_q;
  assign dd_o    = dd_q;

endmodule
`default_nettype wire

[hw/rtl/trov_orient.sv]
// Two-stage exact sign of a*b - c*d: products, then wide subtract.
`default_nettype none
module trov_orient #(
  parameter int unsigned CW = trov_pkg::CoordWidthDef
) (
  input  logic                clk_i,
  input  trov_pkg::trov_ctl_t ctl_i,
  input  logic signed [CW:0]  a_i,
  input  logic signed [CW:0]  b_i,
  input  logic signed [CW:0]  c_i,
  input  logic signed [CW:0]  d_i,
  output logic                neg_o
);
  import trov_pkg::*;

  localparam int unsigned PW = 2 * (CW + 1);

  logic signed [PW-1:0] p1_d, p2_d, p1_q, p2_q;
  logic signed [PW:0]   diff;
  logic                 neg_q;

  assign p1_d = a_i * b_i;
  assign p2_d = c_i * d_i;
  assign diff = (PW+1)'(p1_q) - (PW+1)'(p2_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_mul) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
    if (ctl_i.en_sub) begin
      neg_q <= diff[PW];
    end
  end

  assign neg_o = neg_q;

endmodule
`default_nettype wire

[hw/rtl/triangle_rect_overlap_xz.sv]
// Top level: triangle versus grid-cell overlap in the x/z plane, four-stage pipeline.
//
//  port group  dir  handshake                 beat contents
//  ----------  ---  ------------------------  ------------------------------------
//  input       in   in_valid_i / in_ready_o   three vertices, down flag, cell bounds
//  output      out  out_valid_o / out_ready_i overlaps_o
//
// One beat per cycle is sustained while out_ready_i is high, set by the 24
// parallel orientation units (one multiply stage, one wide subtract stage
// each).
// Stages: wrap/compare/differences, products, signs, final combine into the
// output register. Each stage has its own valid bit and advances when it is
// empty or the next stage advances, so bubbles close up under a stall.
// Reset clears only the valid bits; payload registers are not reset.
`default_nettype none
module triangle_rect_overlap_xz #(
  parameter int unsigned COORD_WIDTH = trov_pkg::CoordWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [trov_pkg::InW-1:0] vertex_a_x_i,
  input  logic signed [trov_pkg::InW-1:0] vertex_a_z_i,
  input  logic signed [trov_pkg::InW-1:0] vertex_b_x_i,
  input  logic signed [trov_pkg::InW-1:0] vertex_b_z_i,
  input  logic signed [trov_pkg::InW-1:0] vertex_c_x_i,
  input  logic signed [trov_pkg::InW-1:0] vertex_c_z_i,
  input  logic                            normal_points_down_i,
  input  logic signed [trov_pkg::InW-1:0] cell_min_x_i,
  input  logic signed [trov_pkg::InW-1:0] cell_min_z_i,
  input  logic signed [trov_pkg::InW-1:0] cell_max_x_i,
  input  logic signed [trov_pkg::InW-1:0] cell_max_z_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            overlaps_o
);
  import trov_pkg::*;

  `include "triangle_rect_overlap_xz_macros.svh"

  // per-stage valid bits and advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: containment and differences
  logic               early1;
  logic signed [COORD_WIDTH:0] da [NumTests];
  logic signed [COORD_WIDTH:0] db [NumTests];
  logic signed [COORD_WIDTH:0] dc [NumTests];
  logic signed [COORD_WIDTH:0] dd [NumTests];

  trov_front #(.CW(COORD_WIDTH)) u_front (
    .clk_i                (clk_i),
    .en_i                 (rdy1),
    .vertex_a_x_i         (vertex_a_x_i),
    .vertex_a_z_i         (vertex_a_z_i),
    .vertex_b_x_i         (vertex_b_x_i),
    .vertex_b_z_i         (vertex_b_z_i),
    .vertex_c_x_i         (vertex_c_x_i),
    .vertex_c_z_i         (vertex_c_z_i),
    .normal_points_down_i (normal_points_down_i),
    .cell_min_x_i         (cell_min_x_i),
    .cell_min_z_i         (cell_min_z_i),
    .cell_max_x_i         (cell_max_x_i),
    .cell_max_z_i         (cell_max_z_i),
    .early_o              (early1),
    .da_o                 (da),
    .db_o                 (db),
    .dc_o                 (dc),
    .dd_o                 (dd)
  );

  // stages 2 and 3: exact orientation signs. The same triangle-edge vs corner
  // sign serves both the corner-inside test and the crossing test.
  trov_ctl_t ctl;
  logic      neg [NumTests];

  assign ctl.en_mul = rdy2;
  assign ctl.en_sub = rdy3;

  for (genvar t = 0; t < NumTests; t++) begin : g_orient
    trov_orient #(.CW(COORD_WIDTH)) u_orient (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .a_i   (da[t]),
      .b_i   (db[t]),
      .c_i   (dc[t]),
      .d_i   (dd[t]),
      .neg_o (neg[t])
    );
  end

  // early-out flag rides alongside
  logic early2_q, early3_q;
  always_ff @(posedge clk_i) begin
    if (rdy2) early2_q <= early1;
    if (rdy3) early3_q <= early2_q;
  end

  // stage 4: early-out flag, corner inside (fixed winding) or strict edge crossing
  logic hit_d, hit_q;
  always_comb begin
    logic [1:0] j;
    logic [1:0] p0;
    logic [1:0] p1;
    j     = '0;
    p0    = '0;
    p1    = '0;
    hit_d = early3_q;
    for (int k = 0; k < NumCorner; k++) begin
      if (!neg[k] && !neg[NumCorner+k] && !neg[2*NumCorner+k]) hit_d = 1'b1;
    end
    for (int e = 0; e < NumCellEdge; e++) begin
      p0 = edge_p0(2'(e));
      p1 = edge_p1(2'(e));
      for (int i = 0; i < NumTri; i++) begin
        j = tri_next(2'(i));
        if ((neg[NumA+e*NumTri+i] != neg[NumA+e*NumTri+j]) &&
            (neg[i*NumCorner+p0] != neg[i*NumCorner+p1])) begin
          hit_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) hit_q <= hit_d;
  end

  assign out_valid_o = v4_q;
  assign overlaps_o  = hit_q;

  // early-out beat moving into the output register must report overlap
  `TROV_ASSERT(a_early_hits, (v3_q && rdy4 && early3_q) |=> overlaps_o,
               "early-out beat lost its overlap")
  // input side only blocks when every stage holds a beat
  `TROV_ASSERT(a_full_when_blocked, !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q),
               "input stalled with a free stage")
  // a held stage-one beat is not dropped
  `TROV_ASSERT(a_hold_stage1, (v1_q && !rdy2) |=> v1_q,
               "stage one beat dropped during stall")

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the triangle versus grid-cell overlap pipeline.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [31:0] coord_t;

  // One input beat: triangle, down flag, cell bounds.
  typedef struct packed {
    coord_t ax, az, bx, bz, cx, cz;
    logic   down;
    coord_t mnx, mnz, mxx, mxz;
  } pair_t;

  logic   clk_i, rst_ni;
  logic   in_valid_i, in_ready_o, out_valid_o, out_ready_i, overlaps_o;
  coord_t vertex_a_x_i, vertex_a_z_i, vertex_b_x_i, vertex_b_z_i;
  coord_t vertex_c_x_i, vertex_c_z_i, cell_min_x_i, cell_min_z_i;
  coord_t cell_max_x_i, cell_max_z_i;
  logic   normal_points_down_i;

  triangle_rect_overlap_xz u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .vertex_a_x_i, .vertex_a_z_i, .vertex_b_x_i, .vertex_b_z_i,
    .vertex_c_x_i, .vertex_c_z_i, .normal_points_down_i,
    .cell_min_x_i, .cell_min_z_i, .cell_max_x_i, .cell_max_z_i,
    .out_valid_o, .out_ready_i, .overlaps_o
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Coordinates are 32-bit, differences fit in 33 bits and products
  // in 66, so 72-bit signed math is exact.
  // ---------------------------------------------------------------------------
  typedef logic signed [71:0] wide_t;

  // sign of a*b - c*d, true when negative
  function automatic logic orient_neg(wide_t a, wide_t b, wide_t c, wide_t d);
    wide_t r;
    r = a * b - c * d;
    return r < 0;
  endfunction

  // do segments p0-p1 and p2-p3 straddle each other (zero as non-negative)
  function automatic logic seg_cross(wide_t p0x, wide_t p0z, wide_t p1x, wide_t p1z,
                                     wide_t p2x, wide_t p2z, wide_t p3x, wide_t p3z);
    logic s0, s1, t0, t1;
    s0 = orient_neg(p1z - p0z, p2x - p1x, p1x - p0x, p2z - p1z);
    s1 = orient_neg(p1z - p0z, p3x - p1x, p1x - p0x, p3z - p1z);
    t0 = orient_neg(p3z - p2z, p0x - p3x, p3x - p2x, p0z - p3z);
    t1 = orient_neg(p3z - p2z, p1x - p3x, p3x - p2x, p1z - p3z);
    return (s0 != s1) && (t0 != t1);
  endfunction

  function automatic logic predict_overlap(pair_t p);
    wide_t tx[3], tz[3], kx[4], kz[4];
    logic  hit;
    int    e0[4], e1[4];
    hit = p.down;
    tx[0] = p.ax; tz[0] = p.az; tx[1] = p.bx; tz[1] = p.bz;
    tx[2] = p.cx; tz[2] = p.cz;
    // corners: lolo, hilo, lohi, hihi
    kx[0] = p.mnx; kz[0] = p.mnz; kx[1] = p.mxx; kz[1] = p.mnz;
    kx[2] = p.mnx; kz[2] = p.mxz; kx[3] = p.mxx; kz[3] = p.mxz;
    // cell edges: bottom, top, left, right
    e0 = '{0, 2, 0, 1};
    e1 = '{1, 3, 2, 3};
    for (int i = 0; i < 3; i++)
      if (kx[0] <= tx[i] && tx[i] <= kx[3] && kz[0] <= tz[i] && tz[i] <= kz[3])
        hit = 1'b1;
    for (int k = 0; k < 4; k++) begin
      logic in_tri;
      in_tri = 1'b1;
      for (int i = 0; i < 3; i++) begin
        int j;
        j = (i + 1) % 3;
        if (orient_neg(tz[i] - kz[k], tx[j] - tx[i], tx[i] - kx[k], tz[j] - tz[i]))
          in_tri = 1'b0;
      end
      if (in_tri) hit = 1'b1;
    end
    for (int e = 0; e < 4; e++)
      for (int i = 0; i < 3; i++)
        if (seg_cross(kx[e0[e]], kz[e0[e]], kx[e1[e]], kz[e1[e]],
                      tx[i], tz[i], tx[(i + 1) % 3], tz[(i + 1) % 3]))
          hit = 1'b1;
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store, expected answers, bookkeeping.
  // ---------------------------------------------------------------------------
  pair_t pending_pairs[$];
  logic  expected_overlap[$];
  int    send_idle_pct, recv_idle_pct;
  int    hold_off_cycles;
  int    mismatches;
  logic  drained_wait;  // sender pauses until every answer is back
  logic  in_beat_taken; // input handshake seen at the last rising edge

  always @(posedge clk_i) begin
    in_beat_taken <= in_valid_i && in_ready_o;
  end

  // Driver: valid stays up with a fixed payload until the beat is taken.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (!in_valid_i || in_beat_taken) begin
        if (pending_pairs.size() > 0 && !drained_wait &&
            $urandom_range(99) >= send_idle_pct) begin
          pair_t p;
          p = pending_pairs.pop_front();
          {vertex_a_x_i, vertex_a_z_i, vertex_b_x_i, vertex_b_z_i, vertex_c_x_i,
           vertex_c_z_i, normal_points_down_i, cell_min_x_i, cell_min_z_i,
           cell_max_x_i, cell_max_z_i} <= p;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall generator; a long hold-off overrides the random idling.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_ready_i     <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict at input acceptance, check at output acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expected_overlap.push_back(predict_overlap(
          {vertex_a_x_i, vertex_a_z_i, vertex_b_x_i, vertex_b_z_i, vertex_c_x_i,
           vertex_c_z_i, normal_points_down_i, cell_min_x_i, cell_min_z_i,
           cell_max_x_i, cell_max_z_i}));
      if (out_valid_o && out_ready_i) begin
        if (expected_overlap.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat, overlaps=%0b", overlaps_o);
        end else begin
          logic want;
          want = expected_overlap.pop_front();
          if (overlaps_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("overlaps mismatch: expected %0b got %0b", want, overlaps_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic coord_t rand_coord(int span);
    case ($urandom_range(9))
      0:       return coord_t'($urandom());
      1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return coord_t'($urandom_range(2 * span) - span);
    endcase
  endfunction

  // Triangles and cells in a shared neighborhood so all tests get exercised.
  function automatic pair_t rand_pair();
    pair_t p;
    int    span;
    coord_t cx0, cz0, w, h;
    span = ($urandom_range(3) == 0) ? 1000 : 40;
    p.ax = rand_coord(span); p.az = rand_coord(span);
    p.bx = rand_coord(span); p.bz = rand_coord(span);
    p.cx = rand_coord(span); p.cz = rand_coord(span);
    p.down = ($urandom_range(15) == 0);
    cx0 = rand_coord(span); cz0 = rand_coord(span);
    w = $urandom_range(span / 2); h = $urandom_range(span / 2);
    if ($urandom_range(19) == 0) begin  // inverted cell
      w = -w; h = -h;
    end
    p.mnx = cx0; p.mnz = cz0; p.mxx = cx0 + w; p.mxz = cz0 + h;
    if ($urandom_range(9) == 0) begin  // wholly random cell bounds
      p.mnx = $urandom(); p.mnz = $urandom(); p.mxx = $urandom(); p.mxz = $urandom();
    end
    return p;
  endfunction

  function automatic pair_t mk(coord_t ax, coord_t az, coord_t bx, coord_t bz,
                               coord_t cx, coord_t cz, logic dn, coord_t mnx,
                               coord_t mnz, coord_t mxx, coord_t mxz);
    pair_t p;
    p = {ax, az, bx, bz, cx, cz, dn, mnx, mnz, mxx, mxz};
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_valid_i || expected_overlap.size() > 0)
      @(posedge clk_i);
  endtask

  localparam coord_t MaxC = 32'sh7fffffff;
  localparam coord_t MinC = 32'sh80000000;
  localparam coord_t One  = 32'sh00010000;

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; out_ready_i = 1'b0;
    {vertex_a_x_i, vertex_a_z_i, vertex_b_x_i, vertex_b_z_i, vertex_c_x_i,
     vertex_c_z_i, normal_points_down_i, cell_min_x_i, cell_min_z_i,
     cell_max_x_i, cell_max_z_i} = '0;
    mismatches = 0; hold_off_cycles = 0; drained_wait = 1'b0;
    send_idle_pct = 28; recv_idle_pct = 83;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: down flag, vertex in cell, corner in ccw/cw triangle, edge
    // crossings, touching cases, inverted and degenerate shapes, extremes.
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 1'b1, 10, 10, 20, 20));
    pending_pairs.push_back(mk(15, 15, 100, 100, 100, 0, 1'b0, 10, 10, 20, 20));
    pending_pairs.push_back(mk(10, 20, 100, 100, 100, 0, 1'b0, 10, 10, 20, 20));
    pending_pairs.push_back(mk(-100, -100, 100, -100, 0, 100, 1'b0, -1, -1, 1, 1));
    pending_pairs.push_back(mk(-100, -100, 0, 100, 100, -100, 1'b0, -1, -1, 1, 1));
    pending_pairs.push_back(mk(-10, 5, 30, 5, 30, 6, 1'b0, 0, 0, 10, 10));
    pending_pairs.push_back(mk(-10, 5, 30, 6, 30, 5, 1'b0, 0, 0, 10, 10));
    pending_pairs.push_back(mk(-10, 0, 30, 0, 30, -5, 1'b0, 0, 0, 10, 10));
    pending_pairs.push_back(mk(50, 50, 60, 50, 55, 60, 1'b0, 0, 0, 10, 10));
    pending_pairs.push_back(mk(15, 15, 100, 100, 100, 0, 1'b0, 20, 20, 10, 10));
    pending_pairs.push_back(mk(-50, 5, 50, 5, 0, 5, 1'b0, 0, 0, 10, 10));
    pending_pairs.push_back(mk(3, 3, 3, 3, 3, 3, 1'b0, 0, 0, 10, 10));
    pending_pairs.push_back(mk(MinC, MinC, MaxC, MinC, 0, MaxC, 1'b0, -One, -One, One, One));
    pending_pairs.push_back(mk(MinC, MinC, 0, MaxC, MaxC, MinC, 1'b0, -One, -One, One, One));
    pending_pairs.push_back(mk(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, 1'b0,
                               MinC, MinC, MaxC, MaxC));
    pending_pairs.push_back(mk(MinC, MaxC, MaxC, MinC, MinC, MinC, 1'b0,
                               MaxC, MaxC, MinC, MinC));
    pending_pairs.push_back(mk(MinC, 0, MaxC, 1, MaxC, -1, 1'b0, MinC, MinC, MinC, MaxC));
    pending_pairs.push_back(mk(-1, -1, -1, -1, -1, -1, 1'b0, -1, -1, -1, -1));
    pending_pairs.push_back(mk(MaxC, MinC, MinC, MaxC, 0, 0, 1'b1, MaxC, MinC, MinC, MaxC));
    wait_drained();

    // Random, three idling phases, with a long receiver hold-off early on.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 83 : 0;
      recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 28 : 0;
      for (int n = 0; n < 550; n++) pending_pairs.push_back(rand_pair());
      if (ph == 0) begin
        @(negedge clk_i) hold_off_cycles = 60;
      end
      if (ph == 2) begin
        // sender pause until the pipe empties, mid phase
        while (pending_pairs.size() > 275) @(posedge clk_i);
        drained_wait = 1'b1;
        while (in_valid_i || expected_overlap.size() > 0) @(posedge clk_i);
        @(negedge clk_i) drained_wait = 1'b0;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_overlap.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
